// ===== design/mbgfe_pkg.sv =====
// Shared types and constants of the marked bit-group frame encoder.
// Holds the request/response payload structs, opcodes, register indexes and mode constants.
// No dependencies.
`default_nettype none

package mbgfe_pkg;

   localparam int POSITION_BITS = 17;
   localparam int LIMIT_W       = 17;
   localparam int CMP_W         = (POSITION_BITS + 1 > LIMIT_W) ? POSITION_BITS + 1 : LIMIT_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_END     = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_ACK_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DATA_END    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ACK_END     = 2'd3;

   localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 17'd4096;

   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [7:0] DATA_MARK  = 8'h80;
   localparam logic [7:0] DATA_LOW   = 8'h7F;
   localparam logic [7:0] ACK_MARK   = 8'h40;
   localparam logic [7:0] ACK_LOW    = 8'h3F;
   localparam logic [2:0] DATA_GROUP = 3'd7;
   localparam logic [2:0] ACK_GROUP  = 3'd3;
   localparam logic [2:0] DATA_BITS  = 3'd7;
   localparam logic [2:0] ACK_BITS   = 3'd6;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] payload;
   } req_type;

   typedef struct packed {
      logic [7:0]  line_byte;
      logic        byte_valid;
      logic        accepted;
      logic        run_last;
      logic [31:0] running_crc;
   } rsp_type;

   typedef struct packed {
      logic en;
      logic two;
   } push_type;

endpackage

`default_nettype wire

// ===== design/marked_bit_group_frame_encoder.sv =====
// An item is registered in the input stage, then its results go into the result queue.
// Throughput: one item per cycle while the result queue has two free entries; an item
// with two results (group wrap, end after a partial byte) takes two of its four entries.
// The queue read port, one result per cycle while rsp_ready holds, sets the sustained rate.
// Reset (synchronous) loads register defaults, write position 1, checksum all ones,
// and empties the input stage and result queue.
// Depends on mbgfe_pkg and mbgfe_rsp_queue.
`default_nettype none

module marked_bit_group_frame_encoder (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_ready,
   input  mbgfe_pkg::req_type                       req_data,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output mbgfe_pkg::rsp_type                       rsp_data,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire [mbgfe_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire [mbgfe_pkg::CSR_DATA_W-1:0]          csr_wdata
);
   import mbgfe_pkg::*;

   localparam int P = POSITION_BITS;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // configuration
   logic               ack_mode_ff;
   logic [LIMIT_W-1:0] frame_limit_ff;
   logic [7:0]         data_end_ff;
   logic [7:0]         ack_end_ff;

   // input stage
   logic    item_valid_ff;
   req_type item_ff;

   // encoder state
   logic [P-1:0] write_position_ff, write_position_in;
   logic [2:0]   group_step_ff, group_step_in;
   logic [7:0]   held_ff, held_in;
   logic [31:0]  checksum_ff, checksum_in;

   logic     room;
   logic     advance;
   push_type push;
   rsp_type  r0, r1;

   logic         ack;
   logic [2:0]   group, bits, step, step_next, sh;
   logic [7:0]   mark, low, shl, shr, base, done, held_new, code;
   logic         wrap;
   logic [P:0]   pos_inc, end_pos;
   logic         byte_ok, end_ok;
   logic [31:0]  crc_new;

   assign csr_ready = 1'b1;
   assign advance   = item_valid_ff && room;
   assign req_ready = !item_valid_ff || room;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_mode_ff    <= 1'b0;
         frame_limit_ff <= FRAME_LIMIT_RESET;
         data_end_ff    <= '0;
         ack_end_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ACK_MODE:    ack_mode_ff    <= csr_wdata[0];
            REG_FRAME_LIMIT: frame_limit_ff <= csr_wdata[LIMIT_W-1:0];
            REG_DATA_END:    data_end_ff    <= csr_wdata[7:0];
            REG_ACK_END:     ack_end_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   always_comb begin
      ack   = ack_mode_ff;
      group = ack ? ACK_GROUP : DATA_GROUP;
      bits  = ack ? ACK_BITS : DATA_BITS;
      mark  = ack ? ACK_MARK : DATA_MARK;
      low   = ack ? ACK_LOW : DATA_LOW;
      code  = ack ? ack_end_ff : data_end_ff;
      // a step left over from the other mode restarts the group, dropping the held byte
      step      = (group_step_ff >= group) ? 3'd0 : group_step_ff;
      sh        = ack ? {step[1:0], 1'b0} : step;
      shl       = (item_ff.payload << sh) & low;
      shr       = item_ff.payload >> (bits - sh);
      base      = (step == 3'd0) ? 8'd0 : held_ff;
      done      = base | mark | shl;
      held_new  = mark | shr;
      step_next = step + 3'd1;
      wrap      = (step_next == group);
      pos_inc   = {1'b0, write_position_ff} + (P+1)'(1);
      end_pos   = {1'b0, write_position_ff} + ((step != 3'd0) ? (P+1)'(1) : '0);
      byte_ok   = (CMP_W'(pos_inc) < CMP_W'(frame_limit_ff));
      end_ok    = (CMP_W'(end_pos) < CMP_W'(frame_limit_ff));
      crc_new   = crc_byte(checksum_ff, item_ff.payload);

      write_position_in = write_position_ff;
      group_step_in     = group_step_ff;
      held_in           = held_ff;
      checksum_in       = checksum_ff;
      push.en  = advance;
      push.two = 1'b0;
      r0 = '{line_byte: 8'd0, byte_valid: 1'b0, accepted: 1'b0, run_last: 1'b1,
             running_crc: checksum_ff};
      r1 = r0;

      case (item_ff.opcode)
         OP_BYTE: begin
            if (byte_ok) begin
               checksum_in       = crc_new;
               held_in           = held_new;
               write_position_in = wrap ? pos_inc[P-1:0] + P'(1) : pos_inc[P-1:0];
               group_step_in     = wrap ? 3'd0 : step_next;
               push.two          = wrap;
               r0 = '{line_byte: done, byte_valid: 1'b1, accepted: 1'b1, run_last: !wrap,
                      running_crc: crc_new};
               r1 = '{line_byte: held_new, byte_valid: 1'b1, accepted: 1'b1, run_last: 1'b1,
                      running_crc: crc_new};
            end
         end
         OP_END: begin
            if (end_ok) begin
               write_position_in = end_pos[P-1:0] + P'(1);
               group_step_in     = 3'd0;
               r1 = '{line_byte: code, byte_valid: 1'b1, accepted: 1'b1, run_last: 1'b1,
                      running_crc: checksum_ff};
               if (step != 3'd0) begin
                  // flush the partial byte ahead of the end code
                  push.two = 1'b1;
                  r0 = '{line_byte: held_ff, byte_valid: 1'b1, accepted: 1'b1, run_last: 1'b0,
                         running_crc: checksum_ff};
               end else begin
                  r0 = r1;
               end
            end
         end
         OP_RESTART: begin
            write_position_in = P'(1);
            group_step_in     = 3'd0;
            held_in           = 8'd0;
            checksum_in       = CRC_INIT;
            r0 = '{line_byte: 8'd0, byte_valid: 1'b0, accepted: 1'b1, run_last: 1'b1,
                   running_crc: CRC_INIT};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_position_ff <= P'(1);
         group_step_ff     <= 3'd0;
         held_ff           <= 8'd0;
         checksum_ff       <= CRC_INIT;
      end else if (advance) begin
         write_position_ff <= write_position_in;
         group_step_ff     <= group_step_in;
         held_ff           <= held_in;
         checksum_ff       <= checksum_in;
      end
   end

   mbgfe_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (r0),
      .push_data1 (r1),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      group_step_ff < DATA_GROUP)
      else $error("group step beyond largest group");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.opcode == OP_RESTART)
      |=> (write_position_ff == P'(1) && checksum_ff == CRC_INIT && group_step_ff == 3'd0))
      else $error("restart did not reinitialize frame state");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !room) |=> (item_valid_ff && $stable(item_ff)))
      else $error("input stage lost a stalled item");

endmodule

`default_nettype wire

// ===== design/mbgfe_rsp_queue.sv =====
// Result queue of the frame encoder: four entries, takes one or two results per push.
// Depends on mbgfe_pkg.
`default_nettype none

module mbgfe_rsp_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  mbgfe_pkg::push_type  push,
   input  mbgfe_pkg::rsp_type   push_data0,
   input  mbgfe_pkg::rsp_type   push_data1,
   output logic                 room,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output mbgfe_pkg::rsp_type   rsp_data
);
   import mbgfe_pkg::*;

   rsp_type              entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_CNT_W-1:0] push_cnt;
   logic                 pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entries_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   // two free entries always cover the largest push
   assign room      = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      push_cnt  = push.en ? (push.two ? RSP_CNT_W'(2) : RSP_CNT_W'(1)) : '0;
      wr_ptr_in = wr_ptr_ff + push_cnt[RSP_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + (pop ? RSP_PTR_W'(1) : '0);
      count_in  = count_ff + push_cnt - (pop ? RSP_CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (push.en) begin
         entries_ff[wr_ptr_ff] <= push_data0;
      end
      if (push.en && push.two) begin
         entries_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push_data1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.en |-> count_ff <= RSP_CNT_W'(RSP_DEPTH - 2))
      else $error("result queue pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue count out of range");

   a_pair_push: assert property (@(posedge clock) disable iff (reset)
      (push.en && push.two && !pop) |=> count_ff == $past(count_ff) + RSP_CNT_W'(2))
      else $error("paired push did not add two entries");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for marked_bit_group_frame_encoder: a directed table, then random frames
// over many register settings, every result checked against an in-bench line-byte/CRC predictor.
// Depends on mbgfe_pkg and the encoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbgfe_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Values read straight off the encoding rules; checked on the first result of an item.
   typedef struct packed {
      logic       on;
      logic [7:0] line_byte;
      logic       byte_valid;
      logic       accepted;
   } pin_type;

   typedef struct packed {
      rsp_type want;
      pin_type pin;
   } line_exp_type;

   typedef struct packed {
      logic                   cfg;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  wdata;
      req_type                it;
      pin_type                pin;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   pin_type                req_pin = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor copy of the encoder registers and frame state
   logic                m_ack;
   logic [LIMIT_W-1:0]  m_limit;
   logic [7:0]          m_data_end;
   logic [7:0]          m_ack_end;
   logic [16:0]         st_pos;
   logic [2:0]          st_step;
   logic [7:0]          st_held;
   logic [31:0]         st_crc;

   line_exp_type pending_lines[$];
   int           errors = 0;
   int           sent = 0;
   bit           req_gaps = 1'b0;
   bit           rsp_stalls = 1'b0;
   int           stall_left = 0;

   marked_bit_group_frame_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2ns clock = ~clock;

   initial begin
      #10ms;
      $display("FAIL marked_bit_group_frame_encoder");
      $finish;
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
      c = c ^ {b, 24'h0};
      for (int i = 0; i < 8; i++)
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic void push_line(logic [7:0] b, logic v, logic acc, logic last,
                                     pin_type pin);
      line_exp_type e;
      e.want.line_byte   = b;
      e.want.byte_valid  = v;
      e.want.accepted    = acc;
      e.want.run_last    = last;
      e.want.running_crc = st_crc;
      e.pin              = pin;
      pending_lines.push_back(e);
   endfunction

   // Pack one raw item into the expected line bytes and advance the frame state.
   function automatic void encode_item(req_type it, pin_type pin);
      logic [2:0]  grp, unit, nbits, s, sh;
      logic [7:0]  mark, lowm, base, done, code;
      logic [17:0] p;
      grp   = m_ack ? ACK_GROUP : DATA_GROUP;
      unit  = m_ack ? 3'd2 : 3'd1;
      nbits = m_ack ? ACK_BITS : DATA_BITS;
      mark  = m_ack ? ACK_MARK : DATA_MARK;
      lowm  = m_ack ? ACK_LOW : DATA_LOW;
      code  = m_ack ? m_ack_end : m_data_end;
      // a step left over from the wider group restarts the group and drops the held byte
      s = (st_step >= grp) ? 3'd0 : st_step;
      case (it.opcode)
         OP_BYTE: begin
            if ({1'b0, st_pos} + 18'd1 < {1'b0, m_limit}) begin
               st_crc  = crc32_step(st_crc, it.payload);
               sh      = s * unit;
               base    = (s == 3'd0) ? 8'h00 : st_held;
               done    = base | mark | ((it.payload << sh) & lowm);
               st_held = mark | (it.payload >> (nbits - sh));
               st_pos  = st_pos + 17'd1;
               s       = s + 3'd1;
               if (s >= grp) begin
                  st_step = 3'd0;
                  st_pos  = st_pos + 17'd1;
                  push_line(done, 1'b1, 1'b1, 1'b0, pin);
                  push_line(st_held, 1'b1, 1'b1, 1'b1, '0);
               end else begin
                  st_step = s;
                  push_line(done, 1'b1, 1'b1, 1'b1, pin);
               end
            end else begin
               push_line(8'h00, 1'b0, 1'b0, 1'b1, pin);
            end
         end
         OP_END: begin
            p = {1'b0, st_pos} + ((s != 3'd0) ? 18'd1 : 18'd0);
            if (p < {1'b0, m_limit}) begin
               st_pos  = p[16:0] + 17'd1;
               st_step = 3'd0;
               if (s != 3'd0) begin
                  push_line(st_held, 1'b1, 1'b1, 1'b0, pin);
                  push_line(code, 1'b1, 1'b1, 1'b1, '0);
               end else begin
                  push_line(code, 1'b1, 1'b1, 1'b1, pin);
               end
            end else begin
               push_line(8'h00, 1'b0, 1'b0, 1'b1, pin);
            end
         end
         OP_RESTART: begin
            st_pos  = 17'd1;
            st_step = 3'd0;
            st_held = 8'h00;
            st_crc  = CRC_INIT;
            push_line(8'h00, 1'b0, 1'b1, 1'b1, pin);
         end
         default: push_line(8'h00, 1'b0, 1'b0, 1'b1, pin);
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Track register writes, predict on each input transfer, compare on each result transfer.
   always @(posedge clock) begin
      line_exp_type e;
      if (reset) begin
         m_ack      = 1'b0;
         m_limit    = FRAME_LIMIT_RESET;
         m_data_end = 8'h00;
         m_ack_end  = 8'h00;
         st_pos     = 17'd1;
         st_step    = 3'd0;
         st_held    = 8'h00;
         st_crc     = CRC_INIT;
         pending_lines.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ACK_MODE:    m_ack      = csr_wdata[0];
               REG_FRAME_LIMIT: m_limit    = csr_wdata[LIMIT_W-1:0];
               REG_DATA_END:    m_data_end = csr_wdata[7:0];
               REG_ACK_END:     m_ack_end  = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            encode_item(req_data, req_pin);
         if (rsp_valid && rsp_ready) begin
            if (pending_lines.size() == 0) begin
               $display("%0t ns: result %p with nothing expected", $time, rsp_data);
               errors++;
            end else begin
               e = pending_lines.pop_front();
               check_field("line_byte", e.want.line_byte, rsp_data.line_byte);
               check_field("byte_valid", e.want.byte_valid, rsp_data.byte_valid);
               check_field("accepted", e.want.accepted, rsp_data.accepted);
               check_field("run_last", e.want.run_last, rsp_data.run_last);
               check_field("running_crc", e.want.running_crc, rsp_data.running_crc);
               if (e.pin.on) begin
                  check_field("table line_byte", e.pin.line_byte, rsp_data.line_byte);
                  check_field("table byte_valid", e.pin.byte_valid, rsp_data.byte_valid);
                  check_field("table accepted", e.pin.accepted, rsp_data.accepted);
               end
            end
         end
      end
   end

   // Result side back-pressure: random stalls, mostly short
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!reset && rsp_stalls && $urandom_range(0, 99) < 25) begin
         stall_left <= idle_len() - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input req_type it, input pin_type pin);
      int unsigned gap;
      gap = 0;
      if (req_gaps && $urandom_range(0, 99) < 35)
         gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      req_pin   <= pin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic feed(input logic [1:0] op);
      req_type it;
      it.opcode  = op;
      it.payload = 8'($urandom_range(0, 255));
      send_item(it, '0);
      if (op != OP_UNUSED) sent++;
   endtask

   // Hold off input and wait until every predicted line byte has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_end_code();
      case ($urandom_range(0, 4))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic dir_row_type cfg_row(logic [CSR_INDEX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] d);
      dir_row_type r;
      r       = '0;
      r.cfg   = 1'b1;
      r.idx   = idx;
      r.wdata = d;
      return r;
   endfunction

   function automatic dir_row_type item_row(logic [1:0] op, logic [7:0] pl);
      dir_row_type r;
      r            = '0;
      r.it.opcode  = op;
      r.it.payload = pl;
      return r;
   endfunction

   function automatic dir_row_type pinned_row(logic [1:0] op, logic [7:0] pl, logic [7:0] b,
                                              logic v, logic acc);
      dir_row_type r;
      r                = item_row(op, pl);
      r.pin.on         = 1'b1;
      r.pin.line_byte  = b;
      r.pin.byte_valid = v;
      r.pin.accepted   = acc;
      return r;
   endfunction

   initial begin
      dir_row_type script [0:35];
      int          n;
      logic [16:0] lim;
      script = '{
         pinned_row(OP_END, 8'h00, 8'h00, 1'b1, 1'b1),        // empty frame: end code only
         cfg_row(REG_DATA_END, 17'hA5),
         cfg_row(REG_ACK_END, 17'h5A),
         pinned_row(OP_BYTE, 8'hFF, 8'hFF, 1'b1, 1'b1),
         pinned_row(OP_BYTE, 8'h00, 8'h81, 1'b1, 1'b1),
         item_row(OP_BYTE, 8'h55),
         item_row(OP_BYTE, 8'hAA),
         item_row(OP_BYTE, 8'h01),
         item_row(OP_BYTE, 8'h80),
         item_row(OP_BYTE, 8'h7F),                             // seventh byte wraps the group
         pinned_row(OP_UNUSED, 8'hFF, 8'h00, 1'b0, 1'b0),
         pinned_row(OP_RESTART, 8'h00, 8'h00, 1'b0, 1'b1),
         cfg_row(REG_ACK_MODE, 17'd1),
         pinned_row(OP_BYTE, 8'h00, 8'h40, 1'b1, 1'b1),
         item_row(OP_BYTE, 8'hFF),
         item_row(OP_BYTE, 8'hC3),
         item_row(OP_BYTE, 8'h3C),
         item_row(OP_END, 8'h00),                              // flush partial, then end code
         cfg_row(REG_ACK_MODE, 17'd0),
         item_row(OP_BYTE, 8'h11),
         item_row(OP_BYTE, 8'h22),
         item_row(OP_BYTE, 8'h33),
         item_row(OP_BYTE, 8'h44),
         cfg_row(REG_ACK_MODE, 17'd1),                         // step now past the ack group
         item_row(OP_BYTE, 8'h99),
         item_row(OP_END, 8'hFF),
         cfg_row(REG_FRAME_LIMIT, 17'd2),
         pinned_row(OP_BYTE, 8'hFF, 8'h00, 1'b0, 1'b0),
         pinned_row(OP_RESTART, 8'hFF, 8'h00, 1'b0, 1'b1),
         pinned_row(OP_END, 8'h00, 8'h5A, 1'b1, 1'b1),
         cfg_row(REG_FRAME_LIMIT, 17'd0),
         pinned_row(OP_BYTE, 8'h00, 8'h00, 1'b0, 1'b0),
         cfg_row(REG_FRAME_LIMIT, 17'd1),
         pinned_row(OP_BYTE, 8'hFF, 8'h00, 1'b0, 1'b0),
         cfg_row(REG_FRAME_LIMIT, 17'h1FFFF),
         cfg_row(REG_ACK_MODE, 17'd0)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gaps   = 1'b1;
      rsp_stalls = 1'b1;
      foreach (script[i]) begin
         if (script[i].cfg)
            write_reg(script[i].idx, script[i].wdata);
         else
            send_item(script[i].it, script[i].pin);
      end

      while (sent < 1850) begin
         // new setting; frame state carries over so mode changes land mid-frame
         if ($urandom_range(0, 1) != 0)
            write_reg(REG_ACK_MODE, CSR_DATA_W'($urandom_range(0, 1)));
         case ($urandom_range(0, 9))
            0:         lim = 17'($urandom_range(0, 3));
            1, 2, 3, 4: lim = 17'($urandom_range(4, 40));
            5, 6:      lim = 17'($urandom_range(41, 600));
            7:         lim = 17'd4096;
            8:         lim = 17'd65536;
            default:   lim = 17'($urandom_range(600, 131071));
         endcase
         if ($urandom_range(0, 3) != 0)
            write_reg(REG_FRAME_LIMIT, lim);
         if ($urandom_range(0, 2) == 0)
            write_reg(REG_DATA_END, CSR_DATA_W'(pick_end_code()));
         if ($urandom_range(0, 2) == 0)
            write_reg(REG_ACK_END, CSR_DATA_W'(pick_end_code()));
         req_gaps   = ($urandom_range(0, 2) != 0);
         rsp_stalls = ($urandom_range(0, 2) != 0);

         n = sent + $urandom_range(100, 200);
         while (sent < n) begin
            if ($urandom_range(0, 99) < 85) begin
               if ($urandom_range(0, 3) != 0) feed(OP_RESTART);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: repeat ($urandom_range(0, 10)) feed(OP_BYTE);
                  6, 7, 8:          repeat ($urandom_range(11, 40)) feed(OP_BYTE);
                  default:          repeat ($urandom_range(41, 120)) feed(OP_BYTE);
               endcase
               if ($urandom_range(0, 9) != 0) feed(OP_END);
            end else begin
               repeat ($urandom_range(1, 6)) feed(2'($urandom_range(0, 3)));
            end
         end
      end

      drain_results();
      if (errors == 0)
         $display("PASS marked_bit_group_frame_encoder");
      else
         $display("FAIL marked_bit_group_frame_encoder");
      $finish;
   end

endmodule
